FILE: design/bdd_pkg.sv
// Shared types, register indexes and the class radius table of the box depth
// deprojection block. No dependencies.
package bdd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COLUMNS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ROWS    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAN_FOV_X     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAN_FOV_Y     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DEPTH     = 3'd4;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 72;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic       known;
    logic [8:0] radius;
  } radius_t;

  function automatic radius_t class_radius(input logic [7:0] cls);
    radius_t r;
    r.known = 1'b1;
    case (cls)
      8'd0:    r.radius = 9'd350;
      8'd10:   r.radius = 9'd400;
      8'd20:   r.radius = 9'd300;
      8'd30:   r.radius = 9'd330;
      8'd40:   r.radius = 9'd375;
      8'd50:   r.radius = 9'd350;
      8'd60:   r.radius = 9'd350;
      8'd70:   r.radius = 9'd330;
      8'd80:   r.radius = 9'd378;
      default: begin
        r.known  = 1'b0;
        r.radius = 9'd300;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: design/box_depth_deprojection_core.sv
// Box depth deprojection: depth frame store, window average and pinhole math.
// Depends on bdd_pkg, bdd_ram and bdd_div.
// Loads can follow back to back. A query scans the (2*WINDOW_HALF)^2 window
// pixels, drains the last frame read, then runs three divisions (average, x and
// y offset), the multiply states ST_MUL1 and ST_MUL2 and the output state; the
// next beat is taken after that. An empty window skips the divisions and
// multiplies, a zero frame half skips its offset division, and an output stall
// holds the block until the result register frees up.
// Reset clears control state and loads register defaults; the frame store is
// not cleared and holds no data until it has been loaded.
module box_depth_deprojection_core #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 256,
  parameter int WINDOW_HALF = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // s_axis_tdata_i: pixel_column, pixel_row, depth_sample, box_left, box_right,
  // box_top, box_bottom, class code (lowest bits first), zero padded.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [bdd_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // s_axis_tuser_i: kind.
  input  logic                                s_axis_tuser_i,
  // m_axis_tdata_o: x_position, y_position, z_position, object_radius,
  // class_echo, class_known, depth_valid (lowest bits first).
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [bdd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bdd_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [15:0]                         cfg_data_i
);

  localparam int CW     = $clog2(MAX_COLUMNS + 1);
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int AW     = $clog2(MAX_COLUMNS * MAX_ROWS);
  localparam int WIN    = 2 * WINDOW_HALF;
  localparam int WIN_W  = $clog2(WIN);
  localparam int CNT_W  = $clog2(WIN * WIN + 1);
  localparam int SUM_W  = 16 + CNT_W;
  localparam int PXW    = CW + 6;
  localparam int PYW    = RW + 6;
  localparam int HW     = (CW > RW) ? CW : RW;
  localparam int DVD_W  = (SUM_W > HW + 16) ? SUM_W : HW + 16;
  localparam int DVS_W  = (CNT_W > HW) ? CNT_W : HW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_DIV_AVG, ST_DIV_NX, ST_DIV_NY,
    ST_MUL1, ST_MUL2, ST_OUT
  } state_e;

  state_e state_q;

  logic [9:0]  cfg_cols_q;
  logic [8:0]  cfg_rows_q;
  logic [15:0] tan_x_q, tan_y_q, max_depth_q;

  // Input beat fields.
  logic [8:0]  in_col;
  logic [7:0]  in_row;
  logic [15:0] in_depth, in_left, in_right, in_top, in_bottom;
  logic [7:0]  in_class;

  assign in_col    = s_axis_tdata_i[8:0];
  assign in_row    = s_axis_tdata_i[16:9];
  assign in_depth  = s_axis_tdata_i[32:17];
  assign in_left   = s_axis_tdata_i[48:33];
  assign in_right  = s_axis_tdata_i[64:49];
  assign in_top    = s_axis_tdata_i[80:65];
  assign in_bottom = s_axis_tdata_i[96:81];
  assign in_class  = s_axis_tdata_i[104:97];

  logic in_fire, load_fire, query_fire, load_ok;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_fire  = in_fire && (s_axis_tuser_i == bdd_pkg::KIND_LOAD);
  assign query_fire = in_fire && (s_axis_tuser_i == bdd_pkg::KIND_QUERY);
  assign load_ok    = (32'(in_col) < MAX_COLUMNS) && (32'(in_row) < MAX_ROWS);

  // Frame size in use, with zero acting as one and saturation at the store size.
  logic [CW-1:0] cols, half_x;
  logic [RW-1:0] rows, half_y;

  always_comb begin
    if (cfg_cols_q == '0) begin
      cols = CW'(1);
    end else if (32'(cfg_cols_q) > MAX_COLUMNS) begin
      cols = CW'(MAX_COLUMNS);
    end else begin
      cols = CW'(cfg_cols_q);
    end
    if (cfg_rows_q == '0) begin
      rows = RW'(1);
    end else if (32'(cfg_rows_q) > MAX_ROWS) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(cfg_rows_q);
    end
    half_x = cols >> 1;
    half_y = rows >> 1;
  end

  // Box centre pixel.
  logic [16:0]      sum_lr, sum_tb;
  logic [17+CW-1:0] prod_cx;
  logic [17+RW-1:0] prod_cy;

  assign sum_lr  = 17'(in_left) + 17'(in_right);
  assign sum_tb  = 17'(in_top) + 17'(in_bottom);
  assign prod_cx = (17 + CW)'(sum_lr) * (17 + CW)'(cols);
  assign prod_cy = (17 + RW)'(sum_tb) * (17 + RW)'(rows);

  logic [CW-1:0]    cx_q;
  logic [RW-1:0]    cy_q;
  logic [7:0]       class_q;
  logic [WIN_W-1:0] wx_q, wy_q;
  logic             hit_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [15:0]      avg_q;
  logic [16:0]      nmx_q, nmy_q;
  logic [31:0]      p1x_q, p1y_q;
  logic [17:0]      x_q, y_q;
  logic [16:0]      z_q;
  logic             dvalid_q;
  logic             div_started_q;
  logic [bdd_pkg::OUT_TDATA_W-1:0] m_data_q;
  logic             m_valid_q;

  // Window pixel under scan; a negative offset shows as a set top bit.
  logic [PXW-1:0] px;
  logic [PYW-1:0] py;
  logic           in_frame;
  logic [AW-1:0]  raddr, waddr;
  logic           rd_en;
  logic [15:0]    rdata;

  always_comb begin
    px       = PXW'(cx_q) + PXW'(wx_q) - PXW'(WINDOW_HALF);
    py       = PYW'(cy_q) + PYW'(wy_q) - PYW'(WINDOW_HALF);
    in_frame = !px[PXW-1] && (px < PXW'(cols)) && !py[PYW-1] && (py < PYW'(rows));
    raddr    = AW'(32'(py[RW-1:0]) * MAX_COLUMNS + 32'(px[CW-1:0]));
    waddr    = AW'(32'(in_row) * MAX_COLUMNS + 32'(in_col));
    rd_en    = (state_q == ST_SCAN) && in_frame;
  end

  // Loads and scan reads never overlap: the scan only runs while no beat is taken.
  bdd_ram #(
    .WIDTH(16),
    .DEPTH(MAX_COLUMNS * MAX_ROWS)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (load_fire && load_ok),
    .waddr_i(waddr),
    .wdata_i(in_depth),
    .re_i   (rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Normalized offsets of the centre from the frame middle.
  logic [PXW-1:0] off_x;
  logic [PYW-1:0] off_y;
  logic           neg_x, neg_y;
  logic [CW-1:0]  mag_x;
  logic [RW-1:0]  mag_y;

  always_comb begin
    off_x = PXW'(cx_q) - PXW'(half_x);
    off_y = PYW'(cy_q) - PYW'(half_y);
    neg_x = off_x[PXW-1];
    neg_y = off_y[PYW-1];
    mag_x = neg_x ? CW'(-off_x) : CW'(off_x);
    mag_y = neg_y ? RW'(-off_y) : RW'(off_y);
  end

  bdd_pkg::div_ctrl_t div_ctrl;
  bdd_pkg::div_stat_t div_stat;
  logic [DVD_W-1:0]   div_dividend, div_quo;
  logic [DVS_W-1:0]   div_divisor;

  always_comb begin
    div_ctrl.start = 1'b0;
    div_dividend   = DVD_W'(sum_q);
    div_divisor    = DVS_W'(cnt_q);
    case (state_q)
      ST_DIV_AVG: div_ctrl.start = !div_started_q && (cnt_q != '0);
      ST_DIV_NX: begin
        div_ctrl.start = !div_started_q && (half_x != '0);
        div_dividend   = DVD_W'({mag_x, 16'b0});
        div_divisor    = DVS_W'(half_x);
      end
      ST_DIV_NY: begin
        div_ctrl.start = !div_started_q && (half_y != '0);
        div_dividend   = DVD_W'({mag_y, 16'b0});
        div_divisor    = DVS_W'(half_y);
      end
      default: div_ctrl.start = 1'b0;
    endcase
  end

  bdd_div #(
    .DIVIDEND_W(DVD_W),
    .DIVISOR_W (DVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_ctrl),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .stat_o    (div_stat),
    .quotient_o(div_quo)
  );

  bdd_pkg::radius_t rad;
  assign rad = bdd_pkg::class_radius(class_q);

  logic [47:0] p2x, p2y;
  assign p2x = 48'(p1x_q) * 48'(avg_q);
  assign p2y = 48'(p1y_q) * 48'(avg_q);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q    <= 10'd425;
      cfg_rows_q    <= 9'd239;
      tan_x_q       <= 16'd40951;
      tan_y_q       <= 16'd24503;
      max_depth_q   <= 16'd20000;
      state_q       <= ST_IDLE;
      hit_q         <= 1'b0;
      div_started_q <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          bdd_pkg::CFG_FRAME_COLUMNS: cfg_cols_q  <= cfg_data_i[9:0];
          bdd_pkg::CFG_FRAME_ROWS:    cfg_rows_q  <= cfg_data_i[8:0];
          bdd_pkg::CFG_TAN_FOV_X:     tan_x_q     <= cfg_data_i;
          bdd_pkg::CFG_TAN_FOV_Y:     tan_y_q     <= cfg_data_i;
          bdd_pkg::CFG_MAX_DEPTH:     max_depth_q <= cfg_data_i;
          default: ;
        endcase
      end

      // In the output state a taken result is replaced by the next one below.
      if (m_valid_q && m_axis_tready_i && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end

      // Read data arrives in the cycle after the address.
      hit_q <= rd_en;
      if (hit_q && (rdata != '0) && (rdata < max_depth_q)) begin
        sum_q <= sum_q + SUM_W'(rdata);
        cnt_q <= cnt_q + CNT_W'(1);
      end

      case (state_q)
        ST_IDLE: begin
          if (query_fire) begin
            cx_q    <= prod_cx[17+CW-1:17];
            cy_q    <= prod_cy[17+RW-1:17];
            class_q <= in_class;
            wx_q    <= '0;
            wy_q    <= '0;
            sum_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (wy_q == WIN_W'(WIN - 1)) begin
            wy_q <= '0;
            if (wx_q == WIN_W'(WIN - 1)) begin
              state_q <= ST_DRAIN;
            end else begin
              wx_q <= wx_q + WIN_W'(1);
            end
          end else begin
            wy_q <= wy_q + WIN_W'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DIV_AVG;
        end
        ST_DIV_AVG: begin
          if (cnt_q == '0) begin
            x_q      <= '0;
            y_q      <= '0;
            z_q      <= '0;
            dvalid_q <= 1'b0;
            state_q  <= ST_OUT;
          end else if (!div_started_q) begin
            div_started_q <= 1'b1;
          end else if (div_stat.done) begin
            avg_q         <= div_quo[15:0];
            div_started_q <= 1'b0;
            state_q       <= ST_DIV_NX;
          end
        end
        ST_DIV_NX: begin
          if (half_x == '0) begin
            nmx_q   <= '0;
            state_q <= ST_DIV_NY;
          end else if (!div_started_q) begin
            div_started_q <= 1'b1;
          end else if (div_stat.done) begin
            nmx_q         <= div_quo[16:0];
            div_started_q <= 1'b0;
            state_q       <= ST_DIV_NY;
          end
        end
        ST_DIV_NY: begin
          if (half_y == '0) begin
            nmy_q   <= '0;
            state_q <= ST_MUL1;
          end else if (!div_started_q) begin
            div_started_q <= 1'b1;
          end else if (div_stat.done) begin
            nmy_q         <= div_quo[16:0];
            div_started_q <= 1'b0;
            state_q       <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          // A normalized offset never exceeds 1.0, so these products fit 32 bits.
          p1x_q   <= 32'({15'b0, nmx_q} * {16'b0, tan_x_q});
          p1y_q   <= 32'({15'b0, nmy_q} * {16'b0, tan_y_q});
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          x_q      <= neg_x ? -18'(p2x[47:32]) : 18'(p2x[47:32]);
          y_q      <= neg_y ? -18'(p2y[47:32]) : 18'(p2y[47:32]);
          z_q      <= 17'(avg_q) + 17'(rad.radius);
          dvalid_q <= 1'b1;
          state_q  <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_data_q  <= {dvalid_q, rad.known, class_q, rad.radius, z_q, y_q, x_q};
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // The divider is only started while it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // Returning read data always belongs to a read issued during the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> $past(state_q) == ST_SCAN)
    else $error("frame read outside the window scan");

  // An empty window reports zero depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_data_q[71]) |-> (m_data_q[52:36] == '0))
    else $error("nonzero depth on an empty window");

endmodule

FILE: design/bdd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module bdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bdd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bdd_pkg for its control and status structs.
module bdd_div #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bdd_pkg::div_ctrl_t      ctrl_i,
  input  logic [DIVIDEND_W-1:0]   dividend_i,
  input  logic [DIVISOR_W-1:0]    divisor_i,
  output bdd_pkg::div_stat_t      stat_o,
  output logic [DIVIDEND_W-1:0]   quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d, dvs_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;
  logic [DIVISOR_W:0]    rem_shift;
  logic                  ge;

  always_comb begin
    rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
    ge        = rem_shift >= {1'b0, dvs_q};
    rem_d     = ge ? DIVISOR_W'(rem_shift - {1'b0, dvs_q}) : DIVISOR_W'(rem_shift);
    quo_d     = {quo_q[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

FILE: tb/sv/box_depth_deprojection_core_test.sv
// Self-checking testbench for box_depth_deprojection_core: streams load and query
// beats under random flow control and checks each result against a local predictor.
// Depends on bdd_pkg and the core RTL.
`timescale 1ns / 1ps

module box_depth_deprojection_core_test;

  localparam int NCOLS = 512;
  localparam int NROWS = 256;
  localparam int HALF_WIN = 6;
  localparam int STORE_SIZE = NCOLS * NROWS;
  localparam logic [bdd_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 3'd5;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 400;

  class deproj_scoreboard;
    logic [15:0] depth_mem [STORE_SIZE];
    bit written [STORE_SIZE];
    int unsigned cols_reg, rows_reg, tan_x, tan_y, max_depth;
    logic [bdd_pkg::OUT_TDATA_W-1:0] expected_q [$];
    int errors;

    function new();
      cols_reg = 425;
      rows_reg = 239;
      tan_x = 40951;
      tan_y = 24503;
      max_depth = 20000;
      errors = 0;
    endfunction

    function void write_reg(logic [bdd_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
      case (idx)
        bdd_pkg::CFG_FRAME_COLUMNS: cols_reg = val & 16'h03FF;
        bdd_pkg::CFG_FRAME_ROWS:    rows_reg = val & 16'h01FF;
        bdd_pkg::CFG_TAN_FOV_X:     tan_x = val;
        bdd_pkg::CFG_TAN_FOV_Y:     tan_y = val;
        bdd_pkg::CFG_MAX_DEPTH:     max_depth = val;
        default: ;
      endcase
    endfunction

    function int unsigned active_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > NCOLS) return NCOLS;
      return cols_reg;
    endfunction

    function int unsigned active_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > NROWS) return NROWS;
      return rows_reg;
    endfunction

    function void box_centre(input logic [15:0] l, r, t, b, output int cx, output int cy);
      longint unsigned sx, sy;
      sx = (longint'(l) + longint'(r)) * active_cols();
      sy = (longint'(t) + longint'(b)) * active_rows();
      cx = int'(sx >> 17);
      cy = int'(sy >> 17);
    endfunction

    function longint norm_offset(longint c, longint size);
      longint half, off, mag;
      half = size / 2;
      off = c - half;
      if (half == 0) return 0;
      mag = (off < 0) ? -off : off;
      mag = (mag * 65536) / half;
      return (off < 0) ? -mag : mag;
    endfunction

    function longint deproject(longint norm, longint unsigned tanq, longint unsigned dep);
      longint unsigned mag, p;
      mag = (norm < 0) ? -norm : norm;
      p = (mag * tanq * dep) >> 32;
      return (norm < 0) ? -longint'(p) : longint'(p);
    endfunction

    function void note_beat(logic kind, logic [bdd_pkg::IN_TDATA_W-1:0] d);
      int cx, cy, px, py;
      longint unsigned sum, cnt, avg, s;
      longint xp, yp, zp;
      bdd_pkg::radius_t rad;
      logic [bdd_pkg::OUT_TDATA_W-1:0] res;
      if (kind == bdd_pkg::KIND_LOAD) begin
        depth_mem[int'(d[16:9]) * NCOLS + int'(d[8:0])] = d[32:17];
        written[int'(d[16:9]) * NCOLS + int'(d[8:0])] = 1'b1;
        return;
      end
      box_centre(d[48:33], d[64:49], d[80:65], d[96:81], cx, cy);
      sum = 0;
      cnt = 0;
      for (px = cx - HALF_WIN; px < cx + HALF_WIN; px++) begin
        if (px < 0 || px >= int'(active_cols())) continue;
        for (py = cy - HALF_WIN; py < cy + HALF_WIN; py++) begin
          if (py < 0 || py >= int'(active_rows())) continue;
          s = depth_mem[py * NCOLS + px];
          if (s > 0 && s < max_depth) begin
            sum += s;
            cnt++;
          end
        end
      end
      rad = class_radius_of(d[104:97]);
      xp = 0;
      yp = 0;
      zp = 0;
      if (cnt != 0) begin
        avg = sum / cnt;
        xp = deproject(norm_offset(cx, active_cols()), tan_x, avg);
        yp = deproject(norm_offset(cy, active_rows()), tan_y, avg);
        zp = avg + rad.radius;
      end
      res = '0;
      res[17:0]  = xp[17:0];
      res[35:18] = yp[17:0];
      res[52:36] = zp[16:0];
      res[61:53] = rad.radius;
      res[69:62] = d[104:97];
      res[70]    = rad.known;
      res[71]    = (cnt != 0);
      expected_q = {expected_q, res};
    endfunction

    // Own class table, kept apart from the package function.
    function bdd_pkg::radius_t class_radius_of(logic [7:0] cls);
      bdd_pkg::radius_t r;
      r.known = 1'b1;
      case (cls)
        8'd0, 8'd50, 8'd60: r.radius = 9'd350;
        8'd10: r.radius = 9'd400;
        8'd20: r.radius = 9'd300;
        8'd30, 8'd70: r.radius = 9'd330;
        8'd40: r.radius = 9'd375;
        8'd80: r.radius = 9'd378;
        default: begin
          r.known = 1'b0;
          r.radius = 9'd300;
        end
      endcase
      return r;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("result error: %s got %0h expected %0h", what, got, want);
    endtask

    task check_result(logic [bdd_pkg::OUT_TDATA_W-1:0] got);
      logic [bdd_pkg::OUT_TDATA_W-1:0] want;
      if (expected_q.size() == 0) begin
        report("result without query", got[31:0], 0);
        return;
      end
      want = expected_q.pop_front();
      if (got[17:0] !== want[17:0]) report("x_position", got[17:0], want[17:0]);
      if (got[35:18] !== want[35:18]) report("y_position", got[35:18], want[35:18]);
      if (got[52:36] !== want[52:36]) report("z_position", got[52:36], want[52:36]);
      if (got[61:53] !== want[61:53]) report("object_radius", got[61:53], want[61:53]);
      if (got[69:62] !== want[69:62]) report("class_echo", got[69:62], want[69:62]);
      if (got[70] !== want[70]) report("class_known", got[70], want[70]);
      if (got[71] !== want[71]) report("depth_valid", got[71], want[71]);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [bdd_pkg::IN_TDATA_W-1:0] s_axis_tdata_i;
  logic s_axis_tuser_i;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [bdd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [bdd_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  deproj_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int beats_sent;
  longint cycles;

  box_depth_deprojection_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("box_depth_deprojection_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // Receiver flow control; a long hold-off is counted down here.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task send_beat(logic kind, logic [bdd_pkg::IN_TDATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = kind;
    s_axis_tdata_i = d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_beat(kind, d);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task load_pixel(int col, int row, logic [15:0] dep);
    logic [bdd_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[8:0] = 9'(col);
    d[16:9] = 8'(row);
    d[32:17] = dep;
    send_beat(bdd_pkg::KIND_LOAD, d);
  endtask

  function logic [15:0] random_depth();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0 || sb.max_depth <= 1) return 16'd0;
    if (pick == 1) return 16'($urandom_range(65535, sb.max_depth));
    return 16'($urandom_range(sb.max_depth - 1, 1));
  endfunction

  // Loads the window pixels of a box. With overwrite clear, only pixels never
  // written get a random depth, so a query never reads an empty store entry.
  task load_window(logic [15:0] l, r, t, b, bit overwrite, logic [15:0] dep);
    int cx, cy, px, py;
    sb.box_centre(l, r, t, b, cx, cy);
    for (px = cx - HALF_WIN; px < cx + HALF_WIN; px++) begin
      for (py = cy - HALF_WIN; py < cy + HALF_WIN; py++) begin
        if (px < 0 || py < 0 || px >= int'(sb.active_cols()) || py >= int'(sb.active_rows()))
          continue;
        if (overwrite) load_pixel(px, py, dep);
        else if (!sb.written[py * NCOLS + px]) load_pixel(px, py, random_depth());
      end
    end
  endtask

  task query_box(logic [15:0] l, r, t, b, logic [7:0] cls);
    logic [bdd_pkg::IN_TDATA_W-1:0] d;
    load_window(l, r, t, b, 1'b0, 16'd0);
    d = '0;
    d[48:33] = l;
    d[64:49] = r;
    d[80:65] = t;
    d[96:81] = b;
    d[104:97] = cls;
    d[32:0] = 33'({$urandom, $urandom});
    send_beat(bdd_pkg::KIND_QUERY, d);
  endtask

  task write_cfg(logic [bdd_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task wait_results_done();
    s_axis_tvalid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function logic [15:0] random_edge();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  function logic [15:0] pick_size(int cap);
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'd1;
    if (pick == 2) return 16'(cap);
    if (pick == 3) return 16'($urandom_range(65535));
    return 16'($urandom_range(40, 1));
  endfunction

  task random_config();
    wait_results_done();
    write_cfg(bdd_pkg::CFG_FRAME_COLUMNS, pick_size(NCOLS));
    write_cfg(bdd_pkg::CFG_FRAME_ROWS, pick_size(NROWS));
    write_cfg(bdd_pkg::CFG_TAN_FOV_X, random_edge());
    write_cfg(bdd_pkg::CFG_TAN_FOV_Y, random_edge());
    case ($urandom_range(4))
      0: write_cfg(bdd_pkg::CFG_MAX_DEPTH, 16'd1);
      1: write_cfg(bdd_pkg::CFG_MAX_DEPTH, 16'hFFFF);
      default: write_cfg(bdd_pkg::CFG_MAX_DEPTH, 16'($urandom_range(65535, 1)));
    endcase
  endtask

  task random_query();
    logic [7:0] cls;
    if ($urandom_range(1)) cls = 8'(10 * $urandom_range(8));
    else cls = 8'($urandom_range(255));
    query_box(random_edge(), random_edge(), random_edge(), random_edge(), cls);
  endtask

  initial begin
    int ph, block_start, target, k;
    bit hold_done, pause_done;
    sb = new();
    cycles = 0;
    beats_sent = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i = bdd_pkg::KIND_LOAD;
    s_axis_tdata_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = bdd_pkg::CFG_FRAME_COLUMNS;
    cfg_data_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: frame corners, centre, every class code, empty windows.
    query_box(16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    query_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd10);
    for (k = 2; k <= 8; k++) query_box(16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'(10 * k));
    query_box(16'h1000, 16'h3000, 16'hE000, 16'hF000, 8'd255);
    query_box(16'h4000, 16'h4000, 16'h4000, 16'h4000, 8'd5);
    load_window(16'h6000, 16'h6000, 16'h6000, 16'h6000, 1'b1, 16'd0);
    query_box(16'h6000, 16'h6000, 16'h6000, 16'h6000, 8'd40);
    load_window(16'h6000, 16'h6000, 16'h6000, 16'h6000, 1'b1, 16'hFFFF);
    query_box(16'h6000, 16'h6000, 16'h6000, 16'h6000, 8'd80);
    load_pixel(511, 255, 16'hFFFF);
    wait_results_done();
    write_cfg(CFG_SPARE, 16'hFFFF);
    write_cfg(bdd_pkg::CFG_FRAME_COLUMNS, 16'd1);
    write_cfg(bdd_pkg::CFG_FRAME_ROWS, 16'd1);
    write_cfg(bdd_pkg::CFG_MAX_DEPTH, 16'hFFFF);
    write_cfg(bdd_pkg::CFG_TAN_FOV_X, 16'hFFFF);
    write_cfg(bdd_pkg::CFG_TAN_FOV_Y, 16'd0);
    query_box(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 8'd30);
    random_config();

    // Random: three flow-control regimes, new register settings every block.
    target = beats_sent;
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 68 : 0;
      recv_stall_pct = (ph == 0) ? 68 : (ph == 1) ? 35 : 0;
      target += 330;
      block_start = beats_sent;
      while (beats_sent < target) begin
        if (beats_sent - block_start >= 150) begin
          random_config();
          block_start = beats_sent;
        end
        if (ph == 0 && !hold_done && beats_sent - block_start >= 40) begin
          // Long output stall while queries keep coming, so the input backs up.
          hold_done = 1'b1;
          hold_left = 3000;
          for (k = 0; k < 6; k++) random_query();
        end
        if (ph == 1 && !pause_done && beats_sent - block_start >= 60) begin
          pause_done = 1'b1;
          wait_results_done();
        end
        if ($urandom_range(99) < 35) random_query();
        else if ($urandom_range(4) == 0)
          load_pixel($urandom_range(NCOLS - 1), $urandom_range(NROWS - 1), random_depth());
        else
          load_pixel($urandom_range(sb.active_cols() - 1), $urandom_range(sb.active_rows() - 1),
                     random_depth());
      end
    end

    wait_results_done();
    if (sb.errors == 0) begin
      $display("box_depth_deprojection_core: match");
    end else begin
      $display("box_depth_deprojection_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bdd_pkg.sv
design/bdd_ram.sv
design/bdd_div.sv
design/box_depth_deprojection_core.sv
tb/sv/box_depth_deprojection_core_test.sv
